// File: hdl/frcs_pkg.sv
// shared types and constants of the flash request chunk splitter
`timescale 1ns / 1ps

package frcs_pkg;

    localparam int ADDR_W = 32;
    localparam int CNT_W = 12;
    localparam int MSZ_W = 33;
    localparam int SMALL_W = 17;
    localparam int CFG_W = 33;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_CNT_W = $clog2(ADDR_W);

    localparam int MAX_REQUEST_BYTES = 2048;
    localparam int MIN_BLOCK_BYTES = 64;

    typedef enum logic [1:0] {
        FUNC_READ       = 2'd0,
        FUNC_WRITE      = 2'd1,
        FUNC_ERASE_SEC  = 2'd2,
        FUNC_ERASE_CHIP = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_ERR           = 2'd1,
        ST_INVAL         = 2'd2,
        ST_NOT_SUPPORTED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_READ       = 3'd0,
        CMD_PROG       = 3'd1,
        CMD_ERASE_SEC  = 3'd2,
        CMD_ERASE_CHIP = 3'd3,
        CMD_NONE       = 3'd4
    } t_command;

    typedef enum logic [2:0] {
        CFG_DEVICE_READY  = 3'd0,
        CFG_MEMORY_SIZE   = 3'd1,
        CFG_BASE_OFFSET   = 3'd2,
        CFG_READ_BLOCK    = 3'd3,
        CFG_PAGE_SIZE     = 3'd4,
        CFG_WRITE_ALIGN   = 3'd5,
        CFG_WRITE_GRANULE = 3'd6,
        CFG_ERASE_BLOCK   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_SECTOR  = 2'd0,
        DIV_ALIGN   = 2'd1,
        DIV_GRANULE = 2'd2,
        DIV_PAGE    = 2'd3
    } t_div_sel;

    typedef enum logic [1:0] {
        OUT_FAIL  = 2'd0,
        OUT_CHIP  = 2'd1,
        OUT_SECT  = 2'd2,
        OUT_CHUNK = 2'd3
    } t_out_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SEC_DIV,
        S_SEC_OUT,
        S_ALN_DIV,
        S_GRN_DIV,
        S_PG_DIV,
        S_CHUNK,
        S_FAIL
    } t_state;

    typedef struct packed {
        logic      accept;
        logic      div_start;
        t_div_sel  div_sel;
        logic      lim_load;
        logic      lim_from_rem;
        logic      out_load;
        t_out_kind out_kind;
        t_status   fail_status;
        logic      chunk_step;
    } t_dp_cmd;

    typedef struct packed {
        logic  ready_zero;
        logic  tmo_zero;
        t_func func;
        logic  count_big;
        logic  count_zero;
        logic  range_bad;
        logic  sect_oor;
        logic  eb_zero;
        logic  align_zero;
        logic  gran_zero;
        logic  blk_zero;
        logic  div_done;
        logic  rem_zero;
        logic  out_free;
        logic  chunk_last;
    } t_dp_sts;

endpackage

// File: hdl/frcs_dp.sv
// datapath: config registers, request registers, shared remainder unit, result register
`timescale 1ns / 1ps

module frcs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [frcs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [frcs_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [1:0]                          i_func,
    input  logic [frcs_pkg::ADDR_W-1:0]         i_start_addr,
    input  logic [frcs_pkg::CNT_W-1:0]          i_byte_count,
    input  logic [frcs_pkg::ADDR_W-1:0]         i_timeout_in,
    input  logic                                i_rsp_ready,
    input  frcs_pkg::t_dp_cmd                   i_cmd,
    output frcs_pkg::t_dp_sts                   o_sts,
    output logic                                o_rsp_valid,
    output logic [1:0]                          o_status,
    output logic [2:0]                          o_command,
    output logic [frcs_pkg::ADDR_W-1:0]         o_device_addr,
    output logic [frcs_pkg::CNT_W-1:0]          o_chunk_bytes,
    output logic [frcs_pkg::ADDR_W-1:0]         o_timeout_out,
    output logic                                o_last
);

    localparam int AW = frcs_pkg::ADDR_W;
    localparam int CW = frcs_pkg::CNT_W;
    localparam int MW = frcs_pkg::MSZ_W;
    localparam int SW = frcs_pkg::SMALL_W;
    localparam int DIV_CW = frcs_pkg::DIV_CNT_W;

    // config registers
    logic                r_dev_ready;
    logic [MW-1:0]       r_mem_size;
    logic [AW-1:0]       r_base;
    logic [AW-1:0]       r_read_block;
    logic [SW-1:0]       r_page_size;
    logic [SW-1:0]       r_write_align;
    logic [SW-1:0]       r_write_granule;
    logic [AW-1:0]       r_erase_block;

    // request registers
    frcs_pkg::t_func     r_func;
    logic [AW-1:0]       r_start;
    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_tmo;
    logic [AW-1:0]       r_addr;
    logic [CW-1:0]       r_left;
    logic [AW-1:0]       r_lim;

    // remainder unit
    logic                r_div_busy;
    logic                r_div_done;
    logic [DIV_CW-1:0]   r_div_cnt;
    logic [AW-1:0]       r_div_a;
    logic [AW-1:0]       r_div_d;
    logic [AW-1:0]       r_div_rem;

    // result register
    logic                r_out_valid;
    frcs_pkg::t_status   r_status;
    frcs_pkg::t_command  r_command;
    logic [AW-1:0]       r_dev_addr;
    logic [CW-1:0]       r_chunk;
    logic [AW-1:0]       r_tmo_out;
    logic                r_last;

    logic [MW-1:0]       msz;
    logic [AW-1:0]       blk_sel;
    logic [AW-1:0]       blk;
    logic                blk_zero;
    logic [CW-1:0]       chunk;
    logic [AW-1:0]       div_a;
    logic [AW-1:0]       div_d;
    logic [AW:0]         div_trial;
    logic                out_free;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_ready     <= 1'b0;
            r_mem_size      <= '0;
            r_base          <= '0;
            r_read_block    <= '0;
            r_page_size     <= SW'(256);
            r_write_align   <= SW'(1);
            r_write_granule <= SW'(1);
            r_erase_block   <= AW'(4096);
        end else if (i_cfg_we) begin
            case (frcs_pkg::t_cfg_idx'(i_cfg_idx))
                frcs_pkg::CFG_DEVICE_READY:  r_dev_ready     <= i_cfg_data[0];
                frcs_pkg::CFG_MEMORY_SIZE:   r_mem_size      <= i_cfg_data[MW-1:0];
                frcs_pkg::CFG_BASE_OFFSET:   r_base          <= i_cfg_data[AW-1:0];
                frcs_pkg::CFG_READ_BLOCK:    r_read_block    <= i_cfg_data[AW-1:0];
                frcs_pkg::CFG_PAGE_SIZE:     r_page_size     <= i_cfg_data[SW-1:0];
                frcs_pkg::CFG_WRITE_ALIGN:   r_write_align   <= i_cfg_data[SW-1:0];
                frcs_pkg::CFG_WRITE_GRANULE: r_write_granule <= i_cfg_data[SW-1:0];
                frcs_pkg::CFG_ERASE_BLOCK:   r_erase_block   <= i_cfg_data[AW-1:0];
                default: begin
                end
            endcase
        end
    end

    // memory size above 2^32 counts as 2^32
    assign msz = r_mem_size[MW-1] ? {1'b1, {(MW-1){1'b0}}} : r_mem_size;

    assign blk_sel  = (r_func == frcs_pkg::FUNC_WRITE) ? {{(AW-SW){1'b0}}, r_page_size}
                                                       : r_read_block;
    assign blk_zero = (blk_sel == '0);
    assign blk      = (!blk_zero && blk_sel < AW'(frcs_pkg::MIN_BLOCK_BYTES))
                      ? AW'(frcs_pkg::MIN_BLOCK_BYTES) : blk_sel;

    assign chunk = (!blk_zero && r_lim < {{(AW-CW){1'b0}}, r_left}) ? r_lim[CW-1:0] : r_left;

    assign out_free = !r_out_valid || i_rsp_ready;

    always_comb begin
        o_sts            = '0;
        o_sts.ready_zero = !r_dev_ready;
        o_sts.tmo_zero   = (r_tmo == '0);
        o_sts.func       = r_func;
        o_sts.count_big  = ({{(AW-CW){1'b0}}, r_count} > AW'(frcs_pkg::MAX_REQUEST_BYTES));
        o_sts.count_zero = (r_count == '0);
        o_sts.sect_oor   = ({1'b0, r_start} >= msz);
        o_sts.range_bad  = o_sts.sect_oor
                           || ({{(MW-CW){1'b0}}, r_count} > (msz - {1'b0, r_start}));
        o_sts.eb_zero    = (r_erase_block == '0);
        o_sts.align_zero = (r_write_align == '0);
        o_sts.gran_zero  = (r_write_granule == '0);
        o_sts.blk_zero   = blk_zero;
        o_sts.div_done   = r_div_done;
        o_sts.rem_zero   = (r_div_rem == '0);
        o_sts.out_free   = out_free;
        o_sts.chunk_last = (chunk == r_left);
    end

    // request and chunk walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func  <= frcs_pkg::t_func'(i_func);
            r_start <= i_start_addr;
            r_count <= i_byte_count;
            r_tmo   <= i_timeout_in;
            r_addr  <= i_start_addr;
            r_left  <= i_byte_count;
        end
        if (i_cmd.lim_load) begin
            r_lim <= i_cmd.lim_from_rem ? (blk - r_div_rem) : blk;
        end
        if (i_cmd.chunk_step) begin
            r_addr <= r_addr + {{(AW-CW){1'b0}}, chunk};
            r_left <= r_left - chunk;
            r_lim  <= blk;
        end
    end

    // operand select for the remainder unit
    always_comb begin
        case (i_cmd.div_sel)
            frcs_pkg::DIV_SECTOR: begin
                div_a = r_start;
                div_d = r_erase_block;
            end
            frcs_pkg::DIV_ALIGN: begin
                div_a = r_start;
                div_d = {{(AW-SW){1'b0}}, r_write_align};
            end
            frcs_pkg::DIV_GRANULE: begin
                div_a = {{(AW-CW){1'b0}}, r_count};
                div_d = {{(AW-SW){1'b0}}, r_write_granule};
            end
            frcs_pkg::DIV_PAGE: begin
                div_a = r_start;
                div_d = blk;
            end
            default: begin
                div_a = r_start;
                div_d = r_erase_block;
            end
        endcase
    end

    // restoring remainder, one dividend bit per cycle
    assign div_trial = {r_div_rem, r_div_a[AW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
            r_div_cnt  <= '0;
        end else begin
            r_div_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= '0;
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_CW'(AW - 1)) begin
                    r_div_busy <= 1'b0;
                    r_div_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_a   <= div_a;
            r_div_d   <= div_d;
            r_div_rem <= '0;
        end else if (r_div_busy) begin
            r_div_a <= {r_div_a[AW-2:0], 1'b0};
            if (div_trial >= {1'b0, r_div_d}) begin
                r_div_rem <= AW'(div_trial - {1'b0, r_div_d});
            end else begin
                r_div_rem <= div_trial[AW-1:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_kind)
                frcs_pkg::OUT_FAIL: begin
                    r_status   <= i_cmd.fail_status;
                    r_command  <= frcs_pkg::CMD_NONE;
                    r_dev_addr <= '0;
                    r_chunk    <= '0;
                    r_tmo_out  <= '0;
                    r_last     <= 1'b1;
                end
                frcs_pkg::OUT_CHIP: begin
                    r_status   <= frcs_pkg::ST_OK;
                    r_command  <= frcs_pkg::CMD_ERASE_CHIP;
                    r_dev_addr <= '0;
                    r_chunk    <= '0;
                    r_tmo_out  <= r_tmo;
                    r_last     <= 1'b1;
                end
                frcs_pkg::OUT_SECT: begin
                    r_status   <= frcs_pkg::ST_OK;
                    r_command  <= frcs_pkg::CMD_ERASE_SEC;
                    r_dev_addr <= r_start - r_div_rem + r_base;
                    r_chunk    <= '0;
                    r_tmo_out  <= r_tmo;
                    r_last     <= 1'b1;
                end
                frcs_pkg::OUT_CHUNK: begin
                    r_status   <= frcs_pkg::ST_OK;
                    r_command  <= (r_func == frcs_pkg::FUNC_WRITE) ? frcs_pkg::CMD_PROG
                                                                   : frcs_pkg::CMD_READ;
                    r_dev_addr <= r_addr + r_base;
                    r_chunk    <= chunk;
                    r_tmo_out  <= r_tmo;
                    r_last     <= (chunk == r_left);
                end
                default: begin
                    r_status   <= i_cmd.fail_status;
                    r_command  <= frcs_pkg::CMD_NONE;
                    r_dev_addr <= '0;
                    r_chunk    <= '0;
                    r_tmo_out  <= '0;
                    r_last     <= 1'b1;
                end
            endcase
        end
    end

    assign o_rsp_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_command     = r_command;
    assign o_device_addr = r_dev_addr;
    assign o_chunk_bytes = r_chunk;
    assign o_timeout_out = r_tmo_out;
    assign o_last        = r_last;

`ifndef SYNTHESIS
    a_div_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_done |-> (r_div_rem < r_div_d))
        else $error("remainder not below divisor");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !r_div_busy)
        else $error("remainder unit restarted while busy");

    a_chunk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && i_cmd.out_kind == frcs_pkg::OUT_CHUNK) |-> (chunk != '0))
        else $error("empty chunk issued");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result register overwritten");
`endif

endmodule

// File: hdl/frcs_ctrl.sv
// controller state machine: request checks, remainder jobs and command issue
`timescale 1ns / 1ps

module frcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  frcs_pkg::t_dp_sts i_sts,
    output frcs_pkg::t_dp_cmd o_cmd
);

    frcs_pkg::t_state r_state;
    frcs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            frcs_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = frcs_pkg::S_CHECK;
                end
            end
            frcs_pkg::S_CHECK: begin
                if (i_sts.ready_zero || i_sts.tmo_zero
                    || i_sts.func == frcs_pkg::FUNC_ERASE_CHIP) begin
                    if (i_sts.out_free) begin
                        n_state = frcs_pkg::S_IDLE;
                    end
                end else if (i_sts.func == frcs_pkg::FUNC_ERASE_SEC) begin
                    if (i_sts.eb_zero || i_sts.sect_oor) begin
                        if (i_sts.out_free) begin
                            n_state = frcs_pkg::S_IDLE;
                        end
                    end else begin
                        n_state = frcs_pkg::S_SEC_DIV;
                    end
                end else if (i_sts.count_big || i_sts.count_zero || i_sts.range_bad) begin
                    if (i_sts.out_free) begin
                        n_state = frcs_pkg::S_IDLE;
                    end
                end else if (i_sts.func == frcs_pkg::FUNC_WRITE) begin
                    if (!i_sts.align_zero) begin
                        n_state = frcs_pkg::S_ALN_DIV;
                    end else if (!i_sts.gran_zero) begin
                        n_state = frcs_pkg::S_GRN_DIV;
                    end else if (!i_sts.blk_zero) begin
                        n_state = frcs_pkg::S_PG_DIV;
                    end else begin
                        n_state = frcs_pkg::S_CHUNK;
                    end
                end else begin
                    n_state = frcs_pkg::S_CHUNK;
                end
            end
            frcs_pkg::S_SEC_DIV: begin
                if (i_sts.div_done) begin
                    n_state = frcs_pkg::S_SEC_OUT;
                end
            end
            frcs_pkg::S_SEC_OUT: begin
                if (i_sts.out_free) begin
                    n_state = frcs_pkg::S_IDLE;
                end
            end
            frcs_pkg::S_ALN_DIV: begin
                if (i_sts.div_done) begin
                    if (!i_sts.rem_zero) begin
                        n_state = frcs_pkg::S_FAIL;
                    end else if (!i_sts.gran_zero) begin
                        n_state = frcs_pkg::S_GRN_DIV;
                    end else if (!i_sts.blk_zero) begin
                        n_state = frcs_pkg::S_PG_DIV;
                    end else begin
                        n_state = frcs_pkg::S_CHUNK;
                    end
                end
            end
            frcs_pkg::S_GRN_DIV: begin
                if (i_sts.div_done) begin
                    if (!i_sts.rem_zero) begin
                        n_state = frcs_pkg::S_FAIL;
                    end else if (!i_sts.blk_zero) begin
                        n_state = frcs_pkg::S_PG_DIV;
                    end else begin
                        n_state = frcs_pkg::S_CHUNK;
                    end
                end
            end
            frcs_pkg::S_PG_DIV: begin
                if (i_sts.div_done) begin
                    n_state = frcs_pkg::S_CHUNK;
                end
            end
            frcs_pkg::S_CHUNK: begin
                if (i_sts.out_free && i_sts.chunk_last) begin
                    n_state = frcs_pkg::S_IDLE;
                end
            end
            frcs_pkg::S_FAIL: begin
                if (i_sts.out_free) begin
                    n_state = frcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = frcs_pkg::S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.div_sel     = frcs_pkg::DIV_SECTOR;
        o_cmd.out_kind    = frcs_pkg::OUT_FAIL;
        o_cmd.fail_status = frcs_pkg::ST_ERR;
        o_req_ready       = 1'b0;
        case (r_state)
            frcs_pkg::S_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
            end
            frcs_pkg::S_CHECK: begin
                if (i_sts.ready_zero) begin
                    o_cmd.out_load = i_sts.out_free;
                end else if (i_sts.tmo_zero) begin
                    o_cmd.out_load    = i_sts.out_free;
                    o_cmd.fail_status = frcs_pkg::ST_INVAL;
                end else if (i_sts.func == frcs_pkg::FUNC_ERASE_CHIP) begin
                    o_cmd.out_load = i_sts.out_free;
                    o_cmd.out_kind = frcs_pkg::OUT_CHIP;
                end else if (i_sts.func == frcs_pkg::FUNC_ERASE_SEC) begin
                    if (i_sts.eb_zero || i_sts.sect_oor) begin
                        o_cmd.out_load = i_sts.out_free;
                    end else begin
                        o_cmd.div_start = 1'b1;
                    end
                end else if (i_sts.count_big) begin
                    o_cmd.out_load    = i_sts.out_free;
                    o_cmd.fail_status = frcs_pkg::ST_INVAL;
                end else if (i_sts.count_zero) begin
                    o_cmd.out_load    = i_sts.out_free;
                    o_cmd.fail_status = frcs_pkg::ST_OK;
                end else if (i_sts.range_bad) begin
                    o_cmd.out_load = i_sts.out_free;
                end else if (i_sts.func == frcs_pkg::FUNC_WRITE) begin
                    if (!i_sts.align_zero) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = frcs_pkg::DIV_ALIGN;
                    end else if (!i_sts.gran_zero) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = frcs_pkg::DIV_GRANULE;
                    end else if (!i_sts.blk_zero) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = frcs_pkg::DIV_PAGE;
                    end else begin
                        o_cmd.lim_load = 1'b1;
                    end
                end else begin
                    o_cmd.lim_load = 1'b1;
                end
            end
            frcs_pkg::S_SEC_OUT: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_kind = frcs_pkg::OUT_SECT;
            end
            frcs_pkg::S_ALN_DIV: begin
                if (i_sts.div_done && i_sts.rem_zero) begin
                    if (!i_sts.gran_zero) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = frcs_pkg::DIV_GRANULE;
                    end else if (!i_sts.blk_zero) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = frcs_pkg::DIV_PAGE;
                    end else begin
                        o_cmd.lim_load = 1'b1;
                    end
                end
            end
            frcs_pkg::S_GRN_DIV: begin
                if (i_sts.div_done && i_sts.rem_zero) begin
                    if (!i_sts.blk_zero) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = frcs_pkg::DIV_PAGE;
                    end else begin
                        o_cmd.lim_load = 1'b1;
                    end
                end
            end
            frcs_pkg::S_PG_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.lim_load     = 1'b1;
                    o_cmd.lim_from_rem = 1'b1;
                end
            end
            frcs_pkg::S_CHUNK: begin
                o_cmd.out_load   = i_sts.out_free;
                o_cmd.out_kind   = frcs_pkg::OUT_CHUNK;
                o_cmd.chunk_step = i_sts.out_free;
            end
            frcs_pkg::S_FAIL: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_chunk_ends_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frcs_pkg::S_CHUNK && i_sts.out_free && i_sts.chunk_last)
        |=> (r_state == frcs_pkg::S_IDLE))
        else $error("chunk walk did not finish on last chunk");

    a_sector_after_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frcs_pkg::S_SEC_OUT) |-> ($past(r_state) == frcs_pkg::S_SEC_DIV
                                              || $past(r_state) == frcs_pkg::S_SEC_OUT))
        else $error("sector result without remainder");

    a_accept_leads_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == frcs_pkg::S_CHECK))
        else $error("transfer not followed by checks");
`endif

endmodule

// File: hdl/flash_request_chunk_splitter_top.sv
// top level of the flash request chunk splitter
// rejected, empty and chip erase requests load their result from the check state; a failed
// write alignment or length pass loads it from the fail state; each remainder pass (sector,
// write alignment, write length, page offset) runs in the remainder unit; sector erase loads its
// command after its pass; chunks follow the checks and passes, then one per cycle while free
// synchronous active-low reset restores register defaults and empties the result register
`timescale 1ns / 1ps

module flash_request_chunk_splitter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [frcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [frcs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  logic [1:0]                     i_func,
    input  logic [frcs_pkg::ADDR_W-1:0]    i_start_addr,
    input  logic [frcs_pkg::CNT_W-1:0]     i_byte_count,
    input  logic [frcs_pkg::ADDR_W-1:0]    i_timeout_in,
    output logic                           o_rsp_valid,
    input  logic                           i_rsp_ready,
    output logic [1:0]                     o_status,
    output logic [2:0]                     o_command,
    output logic [frcs_pkg::ADDR_W-1:0]    o_device_addr,
    output logic [frcs_pkg::CNT_W-1:0]     o_chunk_bytes,
    output logic [frcs_pkg::ADDR_W-1:0]    o_timeout_out,
    output logic                           o_last
);

    frcs_pkg::t_dp_cmd cmd;
    frcs_pkg::t_dp_sts sts;

    frcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    frcs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_start_addr  (i_start_addr),
        .i_byte_count  (i_byte_count),
        .i_timeout_in  (i_timeout_in),
        .i_rsp_ready   (i_rsp_ready),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_rsp_valid   (o_rsp_valid),
        .o_status      (o_status),
        .o_command     (o_command),
        .o_device_addr (o_device_addr),
        .o_chunk_bytes (o_chunk_bytes),
        .o_timeout_out (o_timeout_out),
        .o_last        (o_last)
    );

endmodule
